### rtl/sdspi_pkg.sv
`default_nettype none
package sdspi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAKE,
        PH_CMD,
        PH_POLL,
        PH_READ4,
        PH_DESEL,
        PH_TOKEN,
        PH_DATA,
        PH_CRC
    } phase_t;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_READ  = 2'd1,
        ACT_BYTE  = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_XFER   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_CMD0     = 4'd1;
    localparam logic [3:0] ST_CMD8     = 4'd2;
    localparam logic [3:0] ST_ACMD41   = 4'd3;
    localparam logic [3:0] ST_CMD58    = 4'd4;
    localparam logic [3:0] ST_CMD16    = 4'd5;
    localparam logic [3:0] ST_NOINIT   = 4'd6;
    localparam logic [3:0] ST_CMD17    = 4'd7;
    localparam logic [3:0] ST_TOKEN_TO = 4'd8;

    localparam logic [1:0] REG_SLOW  = 2'd0;
    localparam logic [1:0] REG_FAST  = 2'd1;
    localparam logic [1:0] REG_INITT = 2'd2;
    localparam logic [1:0] REG_TOKT  = 2'd3;

    localparam logic [5:0] CMD_GO_IDLE = 6'd0;
    localparam logic [5:0] CMD_IF_COND = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ    = 6'd17;
    localparam logic [5:0] CMD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP     = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    typedef struct packed {
        logic        valid;
        logic        two;
        kind_t       kind0;
        logic [7:0]  tx_byte;
        logic        select_low;
        logic [7:0]  data_byte;
        logic        last_data;
        logic [3:0]  status;
        logic [7:0]  card_response;
        logic        capacity_high;
        logic [31:0] card_ocr;
    } result_t;

endpackage
`default_nettype wire

### rtl/sdspi_ctrl.sv
`default_nettype none
module sdspi_ctrl #(
    parameter int BLOCK_BYTES = 512,
    parameter int POLL_LIMIT  = 16,
    parameter int WAKE_BYTES  = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [1:0]        action,
    input  wire logic [31:0]       block_address,
    input  wire logic [7:0]        received_byte,
    input  wire logic [15:0]       init_timeout_ms,
    input  wire logic [15:0]       token_timeout_ms,
    output sdspi_pkg::result_t     res,
    output logic                   card_ready
);
    import sdspi_pkg::*;

    localparam int CW = (BLOCK_BYTES > 64) ? $clog2(BLOCK_BYTES + 1) : 7;
    localparam int PW = $clog2(POLL_LIMIT + 1);

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] poll_reg, poll_next;
    logic [15:0] ms_reg, ms_next;
    logic [5:0]  idx_reg, idx_next;
    logic [31:0] arg_reg, arg_next;
    logic [7:0]  resp_reg, resp_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] ocr_reg, ocr_next;
    logic [3:0]  pend_reg, pend_next;
    logic        v2_reg, v2_next, rdy_reg, rdy_next, ba_reg, ba_next;
    result_t     r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            poll_reg  <= '0;
            ms_reg    <= '0;
            idx_reg   <= '0;
            arg_reg   <= '0;
            resp_reg  <= 8'hff;
            sh_reg    <= '0;
            ocr_reg   <= '0;
            pend_reg  <= '0;
            v2_reg    <= 1'b0;
            rdy_reg   <= 1'b0;
            ba_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            poll_reg  <= poll_next;
            ms_reg    <= ms_next;
            idx_reg   <= idx_next;
            arg_reg   <= arg_next;
            resp_reg  <= resp_next;
            sh_reg    <= sh_next;
            ocr_reg   <= ocr_next;
            pend_reg  <= pend_next;
            v2_reg    <= v2_next;
            rdy_reg   <= rdy_next;
            ba_reg    <= ba_next;
        end
    end

    assign card_ready = rdy_next;
    assign res = r;

    always_comb
    begin
        logic [7:0] b;
        logic       xfer;
        logic [7:0] xtx;
        logic       xsel;
        logic       fin;
        logic [3:0] fst;
        logic [7:0] cb;
        logic       go_cmd;
        logic [5:0] c_idx;
        logic [31:0] c_arg;
        logic       go_des;
        logic [3:0] d_pend;
        logic       go_r4;
        logic [5:0] nb;
        logic [31:0] sh2;
        logic [31:0] baddr;
        b = received_byte;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        poll_next = poll_reg;
        ms_next = ms_reg;
        idx_next = idx_reg;
        arg_next = arg_reg;
        resp_next = resp_reg;
        sh_next = sh_reg;
        ocr_next = ocr_reg;
        pend_next = pend_reg;
        v2_next = v2_reg;
        rdy_next = rdy_reg;
        ba_next = ba_reg;
        xfer = 1'b0;
        xtx = 8'hff;
        xsel = 1'b1;
        fin = 1'b0;
        fst = ST_OK;
        go_cmd = 1'b0;
        c_idx = '0;
        c_arg = '0;
        go_des = 1'b0;
        d_pend = ST_OK;
        go_r4 = 1'b0;
        r = '0;
        nb = 6'(cnt_reg) + 6'd1;
        sh2 = {sh_reg[23:0], b};
        baddr = ba_reg ? block_address
                       : 32'(64'(block_address) * 64'(BLOCK_BYTES));
        unique case (nb[2:0])
            3'd1: cb = {2'b01, idx_reg};
            3'd2: cb = arg_reg[31:24];
            3'd3: cb = arg_reg[23:16];
            3'd4: cb = arg_reg[15:8];
            3'd5: cb = arg_reg[7:0];
            default: cb = (idx_reg == CMD_GO_IDLE) ? 8'h95 :
                          (idx_reg == CMD_IF_COND) ? 8'h87 : 8'h01;
        endcase

        priority if (action == ACT_TICK)
        begin
            if (ms_reg != 16'hffff)
                ms_next = ms_reg + 16'd1;
        end
        else if (action == ACT_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                rdy_next = 1'b0;
                ba_next = 1'b0;
                v2_next = 1'b0;
                ocr_next = '0;
                pend_next = '0;
                resp_next = 8'hff;
                phase_next = PH_WAKE;
                cnt_next = '0;
                xfer = 1'b1;
                xsel = 1'b0;
            end
        end
        else if (action == ACT_READ)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (!rdy_reg)
                begin
                    fin = 1'b1;
                    fst = ST_NOINIT;
                end
                else
                begin
                    pend_next = '0;
                    go_cmd = 1'b1;
                    c_idx = CMD_READ;
                    c_arg = baddr;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_WAKE:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (32'(cnt_reg) + 1 < WAKE_BYTES)
                    begin
                        xfer = 1'b1;
                        xsel = 1'b0;
                    end
                    else
                    begin
                        ms_next = '0;
                        go_cmd = 1'b1;
                        c_idx = CMD_GO_IDLE;
                    end
                end
                PH_CMD:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    xfer = 1'b1;
                    if (nb <= 6'd6)
                        xtx = cb;
                    else
                    begin
                        phase_next = PH_POLL;
                        poll_next = '0;
                    end
                end
                PH_POLL:
                begin
                    poll_next = poll_reg + 1'b1;
                    if (!b[7] || 32'(poll_reg) + 1 >= POLL_LIMIT)
                    begin
                        resp_next = b;
                        unique case (idx_reg)
                            CMD_IF_COND:
                            begin
                                if (b == 8'h01)
                                    go_r4 = 1'b1;
                                else if (b[2])
                                begin
                                    v2_next = 1'b0;
                                    go_des = 1'b1;
                                end
                                else
                                begin
                                    go_des = 1'b1;
                                    d_pend = ST_CMD8;
                                end
                            end
                            CMD_APP:
                            begin
                                go_des = 1'b1;
                                d_pend = (b > 8'h01) ? ST_ACMD41 : ST_OK;
                            end
                            CMD_BLOCKLEN:
                            begin
                                go_des = 1'b1;
                                d_pend = (b != 8'h00) ? ST_CMD16 : ST_OK;
                            end
                            CMD_READ_OCR:
                            begin
                                if (b != 8'h00)
                                begin
                                    go_des = 1'b1;
                                    d_pend = ST_CMD58;
                                end
                                else
                                    go_r4 = 1'b1;
                            end
                            CMD_READ:
                            begin
                                if (b != 8'h00)
                                begin
                                    go_des = 1'b1;
                                    d_pend = ST_CMD17;
                                end
                                else
                                begin
                                    phase_next = PH_TOKEN;
                                    ms_next = '0;
                                    xfer = 1'b1;
                                end
                            end
                            default: go_des = 1'b1;
                        endcase
                    end
                    else
                        xfer = 1'b1;
                end
                PH_READ4:
                begin
                    sh_next = sh2;
                    cnt_next = cnt_reg + 1'b1;
                    if (nb < 6'd4)
                        xfer = 1'b1;
                    else
                    begin
                        if (idx_reg == CMD_IF_COND)
                            v2_next = (sh2[11:0] == 12'h1aa);
                        else
                        begin
                            ocr_next = sh2;
                            ba_next = v2_reg && sh2[30];
                        end
                        go_des = 1'b1;
                    end
                end
                PH_DESEL:
                begin
                    if (pend_reg != ST_OK)
                    begin
                        fin = 1'b1;
                        fst = pend_reg;
                    end
                    else
                    begin
                        unique case (idx_reg)
                            CMD_GO_IDLE:
                            begin
                                if (resp_reg == 8'h01)
                                begin
                                    go_cmd = 1'b1;
                                    c_idx = CMD_IF_COND;
                                    c_arg = 32'h000001aa;
                                end
                                else if (ms_reg < init_timeout_ms)
                                begin
                                    go_cmd = 1'b1;
                                    c_idx = CMD_GO_IDLE;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                    fst = ST_CMD0;
                                end
                            end
                            CMD_IF_COND:
                            begin
                                ms_next = '0;
                                go_cmd = 1'b1;
                                c_idx = CMD_APP;
                            end
                            CMD_APP:
                            begin
                                go_cmd = 1'b1;
                                c_idx = CMD_OP_COND;
                                c_arg = v2_reg ? 32'h40000000 : 32'h0;
                            end
                            CMD_OP_COND:
                            begin
                                go_cmd = 1'b1;
                                if (resp_reg == 8'h00)
                                    c_idx = CMD_READ_OCR;
                                else if (ms_reg >= init_timeout_ms)
                                begin
                                    go_cmd = 1'b0;
                                    fin = 1'b1;
                                    fst = ST_ACMD41;
                                end
                                else
                                    c_idx = CMD_APP;
                            end
                            CMD_READ_OCR:
                            begin
                                if (!ba_reg)
                                begin
                                    go_cmd = 1'b1;
                                    c_idx = CMD_BLOCKLEN;
                                    c_arg = 32'(BLOCK_BYTES);
                                end
                                else
                                begin
                                    rdy_next = 1'b1;
                                    fin = 1'b1;
                                end
                            end
                            CMD_BLOCKLEN:
                            begin
                                rdy_next = 1'b1;
                                fin = 1'b1;
                            end
                            default: fin = 1'b1;
                        endcase
                    end
                end
                PH_TOKEN:
                begin
                    if (b == 8'hfe)
                    begin
                        phase_next = PH_DATA;
                        cnt_next = '0;
                        xfer = 1'b1;
                    end
                    else if (ms_reg < token_timeout_ms)
                        xfer = 1'b1;
                    else
                    begin
                        go_des = 1'b1;
                        d_pend = ST_TOKEN_TO;
                    end
                end
                PH_DATA:
                begin
                    r.two = 1'b1;
                    r.data_byte = b;
                    r.last_data = (32'(cnt_reg) + 1 >= BLOCK_BYTES);
                    xfer = 1'b1;
                    if (32'(cnt_reg) + 1 >= BLOCK_BYTES)
                    begin
                        phase_next = PH_CRC;
                        cnt_next = '0;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                PH_CRC:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (nb < 6'd2)
                        xfer = 1'b1;
                    else
                        go_des = 1'b1;
                end
                default: ;
            endcase
        end

        if (go_cmd)
        begin
            idx_next = c_idx;
            arg_next = c_arg;
            cnt_next = '0;
            phase_next = PH_CMD;
            xfer = 1'b1;
        end
        if (go_r4)
        begin
            phase_next = PH_READ4;
            cnt_next = '0;
            sh_next = '0;
            xfer = 1'b1;
        end
        if (go_des)
        begin
            pend_next = d_pend;
            phase_next = PH_DESEL;
            xfer = 1'b1;
            xsel = 1'b0;
        end
        if (fin)
            phase_next = PH_IDLE;

        r.valid = xfer || fin;
        r.kind0 = r.two ? KIND_DATA : (fin ? KIND_FINISH : KIND_XFER);
        r.tx_byte = xtx;
        r.select_low = xsel;
        r.status = fst;
        r.card_response = resp_next;
        r.capacity_high = ba_next;
        r.card_ocr = ocr_next;
    end

    always_ff @(posedge clk)
    begin
        if (rst_n && step && phase_reg == PH_CMD)
            assert (cnt_reg <= CW'(6))
                else $error("command byte count overrun");
    end

    property p_rdy_idle;
        @(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_DESEL && rdy_next && !rdy_reg) |-> phase_next == PH_IDLE;
    endproperty
    a_rdy_idle: assert property (p_rdy_idle) else $error("ready set outside finish");

    property p_tick_hold;
        @(posedge clk) disable iff (!rst_n)
        (step && action == ACT_TICK) |=> $stable(phase_reg);
    endproperty
    a_tick_hold: assert property (p_tick_hold) else $error("tick moved phase");

    property p_two_data;
        @(posedge clk) disable iff (!rst_n)
        (step && r.two) |-> (phase_reg == PH_DATA && r.valid);
    endproperty
    a_two_data: assert property (p_two_data) else $error("data result outside data phase");

endmodule
`default_nettype wire

### rtl/sdspi_outq.sv
`default_nettype none
module sdspi_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sdspi_pkg::result_t     res,
    input  wire logic              push,
    input  wire logic [7:0]        divider,
    output logic                   busy,
    output logic                   valid,
    input  wire logic              stall,
    output logic [1:0]             kind,
    output logic [7:0]             tx_byte,
    output logic                   select_low,
    output logic [7:0]             spi_divider,
    output logic [7:0]             data_byte,
    output logic                   last_data,
    output logic [3:0]             status,
    output logic [7:0]             card_response,
    output logic                   capacity_high,
    output logic [31:0]            card_ocr
);
    import sdspi_pkg::*;

    // up to two results per request: data byte then transfer
    result_t    held_reg;
    logic [7:0] div_reg;
    logic [1:0] cnt_reg;
    logic       take;

    assign take = valid && !stall;
    assign valid = cnt_reg != 2'd0;
    assign busy = valid && !(take && cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (push)
            cnt_reg <= (res.valid ? 2'd1 : 2'd0) + (res.two ? 2'd1 : 2'd0);
        else if (take)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            held_reg <= res;
            div_reg <= divider;
        end
    end

    always_comb
    begin
        kind = KIND_XFER;
        tx_byte = '0;
        select_low = 1'b0;
        spi_divider = '0;
        data_byte = '0;
        last_data = 1'b0;
        status = '0;
        card_response = '0;
        capacity_high = 1'b0;
        card_ocr = '0;
        if (cnt_reg == 2'd2)
        begin
            kind = KIND_DATA;
            data_byte = held_reg.data_byte;
            last_data = held_reg.last_data;
        end
        else if (held_reg.kind0 == KIND_FINISH)
        begin
            kind = KIND_FINISH;
            status = held_reg.status;
            card_response = held_reg.card_response;
            capacity_high = held_reg.capacity_high;
            card_ocr = held_reg.card_ocr;
        end
        else
        begin
            tx_byte = held_reg.tx_byte;
            select_low = held_reg.select_low;
            spi_divider = div_reg;
        end
    end

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        push |-> !busy;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("result count overflow");

    property p_drain;
        @(posedge clk) disable iff (!rst_n)
        (take && !push && cnt_reg == 2'd2) |=> cnt_reg == 2'd1;
    endproperty
    a_drain: assert property (p_drain) else $error("pair drain slip");

endmodule
`default_nettype wire

### rtl/sd_spi_init_and_block_read.sv
// SD card host in SPI mode, stepped one byte exchange per request. Requests
// are start (init), read block, received byte and millisecond tick. Each
// request's one or two results sit in an output register and the next
// request is taken in the same cycle the last pending result leaves, so with
// no output stall one request per cycle is sustained, except after a data
// byte, which yields a data result and a transfer that must both leave first.
`default_nettype none
module sd_spi_init_and_block_read #(
    parameter int BLOCK_BYTES = 512,
    parameter int POLL_LIMIT  = 16,
    parameter int WAKE_BYTES  = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  received_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       tx_byte,
    output logic             select_low,
    output logic [7:0]       spi_divider,
    output logic [7:0]       data_byte,
    output logic             last_data,
    output logic [3:0]       status,
    output logic [7:0]       card_response,
    output logic             capacity_high,
    output logic [31:0]      card_ocr
);
    import sdspi_pkg::*;

    logic [7:0]  slow_reg, fast_reg;
    logic [15:0] initt_reg, tokt_reg;
    logic        step, busy, rdy;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg  <= 8'd124;
            fast_reg  <= 8'd1;
            initt_reg <= 16'd1500;
            tokt_reg  <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOW:  slow_reg  <= cfg_data[7:0];
                REG_FAST:  fast_reg  <= cfg_data[7:0];
                REG_INITT: initt_reg <= cfg_data;
                REG_TOKT:  tokt_reg  <= cfg_data;
            endcase
        end
    end

    assign in_stall = busy;
    assign step = in_valid && !busy;

    sdspi_ctrl #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .POLL_LIMIT(POLL_LIMIT),
        .WAKE_BYTES(WAKE_BYTES)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .action(action),
        .block_address(block_address),
        .received_byte(received_byte),
        .init_timeout_ms(initt_reg),
        .token_timeout_ms(tokt_reg),
        .res(res),
        .card_ready(rdy)
    );

    // divider follows card_ready as it stands when the transfer is produced
    sdspi_outq u_outq (
        .clk(clk),
        .rst_n(rst_n),
        .res(res),
        .push(step),
        .divider((rdy && !(res.kind0 == KIND_FINISH)) ? fast_reg : slow_reg),
        .busy(busy),
        .valid(out_valid),
        .stall(out_stall),
        .kind(kind),
        .tx_byte(tx_byte),
        .select_low(select_low),
        .spi_divider(spi_divider),
        .data_byte(data_byte),
        .last_data(last_data),
        .status(status),
        .card_response(card_response),
        .capacity_high(capacity_high),
        .card_ocr(card_ocr)
    );

endmodule
`default_nettype wire

### dv/sd_spi_init_and_block_read_test.sv
`default_nettype none
module sd_spi_init_and_block_read_test;
    import sdspi_pkg::*;

    typedef struct {
        logic [1:0]  act;
        logic [31:0] lba;
        logic [7:0]  rx;
    } req_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic        sel;
        logic [7:0]  div;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  st;
        logic [7:0]  resp;
        logic        cap;
        logic [31:0] ocr;
    } card_out_t;

    localparam int BLK = 512;
    localparam int POLLS = 16;
    localparam int WAKES = 10;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SLOW;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_TICK;
    logic [31:0] block_address = '0;
    logic [7:0]  received_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        select_low;
    logic [7:0]  spi_divider;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [3:0]  status;
    logic [7:0]  card_response;
    logic        capacity_high;
    logic [31:0] card_ocr;

    sd_spi_init_and_block_read u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .block_address(block_address),
        .received_byte(received_byte), .out_valid(out_valid),
        .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
        .select_low(select_low), .spi_divider(spi_divider),
        .data_byte(data_byte), .last_data(last_data), .status(status),
        .card_response(card_response), .capacity_high(capacity_high),
        .card_ocr(card_ocr)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // host state mirror
    logic [7:0]  slow_div = 8'd124;
    logic [7:0]  fast_div = 8'd1;
    logic [15:0] init_to = 16'd1500;
    logic [15:0] tok_to = 16'd500;
    phase_t      ph = PH_IDLE;
    logic [9:0]  nbytes = '0;
    logic [4:0]  npolls = '0;
    logic [15:0] ms = '0;
    logic [5:0]  cmd = '0;
    logic [31:0] cmd_arg = '0;
    logic [7:0]  r1 = 8'hff;
    logic [31:0] shreg = '0;
    logic        v2 = 1'b0;
    logic        ready = 1'b0;
    logic        hc = 1'b0;
    logic [31:0] ocr = '0;
    logic [3:0]  pend_st = '0;

    req_t        req_q[$];
    card_out_t   card_out_q[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_blocks = 0;
    int          n_inits = 0;
    int          cyc = 0;
    int          idle_mode = 0;
    int          fail_pct = 0;
    int          tick_pct = 5;
    bit          hold = 1'b0;

    task automatic push_xfer(input logic [7:0] t, input logic s);
        card_out_t e;
        e = '{default: '0};
        e.kind = KIND_XFER;
        e.tx = t;
        e.sel = s;
        e.div = ready ? fast_div : slow_div;
        card_out_q.push_back(e);
    endtask

    task automatic push_done(input logic [3:0] st);
        card_out_t e;
        e = '{default: '0};
        e.kind = KIND_FINISH;
        e.st = st;
        e.resp = r1;
        e.cap = hc;
        e.ocr = ocr;
        card_out_q.push_back(e);
        ph = PH_IDLE;
    endtask

    task automatic issue_cmd(input logic [5:0] idx, input logic [31:0] arg);
        cmd = idx;
        cmd_arg = arg;
        nbytes = '0;
        ph = PH_CMD;
        push_xfer(8'hff, 1'b1);
    endtask

    task automatic go_desel(input logic [3:0] p);
        pend_st = p;
        ph = PH_DESEL;
        push_xfer(8'hff, 1'b0);
    endtask

    task automatic go_read4();
        ph = PH_READ4;
        nbytes = '0;
        shreg = '0;
        push_xfer(8'hff, 1'b1);
    endtask

    function automatic logic [7:0] frame_byte(input logic [9:0] n);
        case (n)
            10'd1: frame_byte = 8'h40 | {2'b00, cmd};
            10'd2: frame_byte = cmd_arg[31:24];
            10'd3: frame_byte = cmd_arg[23:16];
            10'd4: frame_byte = cmd_arg[15:8];
            10'd5: frame_byte = cmd_arg[7:0];
            default: frame_byte = (cmd == CMD_GO_IDLE) ? 8'h95 :
                                  (cmd == CMD_IF_COND) ? 8'h87 : 8'h01;
        endcase
    endfunction

    task automatic on_r1();
        case (cmd)
            CMD_IF_COND:
                if (r1 == 8'h01) go_read4();
                else if (r1[2])
                begin
                    v2 = 1'b0;
                    go_desel(ST_OK);
                end
                else go_desel(ST_CMD8);
            CMD_APP: go_desel(r1 > 8'h01 ? ST_ACMD41 : ST_OK);
            CMD_BLOCKLEN: go_desel(r1 != 8'h00 ? ST_CMD16 : ST_OK);
            CMD_READ_OCR:
                if (r1 != 8'h00) go_desel(ST_CMD58);
                else go_read4();
            CMD_READ:
                if (r1 != 8'h00) go_desel(ST_CMD17);
                else
                begin
                    ph = PH_TOKEN;
                    ms = '0;
                    push_xfer(8'hff, 1'b1);
                end
            default: go_desel(ST_OK);
        endcase
    endtask

    task automatic on_desel();
        if (pend_st != ST_OK) push_done(pend_st);
        else
            case (cmd)
                CMD_GO_IDLE:
                    if (r1 == 8'h01) issue_cmd(CMD_IF_COND, 32'h0000_01aa);
                    else if (ms < init_to) issue_cmd(CMD_GO_IDLE, 32'h0);
                    else push_done(ST_CMD0);
                CMD_IF_COND:
                begin
                    ms = '0;
                    issue_cmd(CMD_APP, 32'h0);
                end
                CMD_APP: issue_cmd(CMD_OP_COND, v2 ? 32'h4000_0000 : 32'h0);
                CMD_OP_COND:
                    if (r1 == 8'h00) issue_cmd(CMD_READ_OCR, 32'h0);
                    else if (ms >= init_to) push_done(ST_ACMD41);
                    else issue_cmd(CMD_APP, 32'h0);
                CMD_READ_OCR:
                    if (!hc) issue_cmd(CMD_BLOCKLEN, 32'(BLK));
                    else
                    begin
                        ready = 1'b1;
                        push_done(ST_OK);
                    end
                CMD_BLOCKLEN:
                begin
                    ready = 1'b1;
                    push_done(ST_OK);
                end
                default: push_done(ST_OK);
            endcase
    endtask

    task automatic host_step(input req_t r);
        card_out_t e;
        if (r.act == ACT_TICK)
        begin
            if (ms != 16'hffff) ms = ms + 16'd1;
        end
        else if (r.act == ACT_START)
        begin
            if (ph == PH_IDLE)
            begin
                ready = 1'b0; hc = 1'b0; v2 = 1'b0; ocr = '0; pend_st = '0; r1 = 8'hff;
                ph = PH_WAKE;
                nbytes = '0;
                n_inits++;
                push_xfer(8'hff, 1'b0);
            end
        end
        else if (r.act == ACT_READ)
        begin
            if (ph == PH_IDLE)
            begin
                if (!ready) push_done(ST_NOINIT);
                else
                begin
                    pend_st = '0;
                    issue_cmd(CMD_READ, hc ? r.lba : 32'(r.lba * BLK));
                end
            end
        end
        else
            case (ph)
                PH_WAKE:
                begin
                    nbytes++;
                    if (nbytes < WAKES) push_xfer(8'hff, 1'b0);
                    else
                    begin
                        ms = '0;
                        issue_cmd(CMD_GO_IDLE, 32'h0);
                    end
                end
                PH_CMD:
                begin
                    nbytes++;
                    if (nbytes <= 10'd6) push_xfer(frame_byte(nbytes), 1'b1);
                    else
                    begin
                        ph = PH_POLL;
                        npolls = '0;
                        push_xfer(8'hff, 1'b1);
                    end
                end
                PH_POLL:
                begin
                    npolls++;
                    if (!r.rx[7] || npolls >= POLLS)
                    begin
                        r1 = r.rx;
                        on_r1();
                    end
                    else push_xfer(8'hff, 1'b1);
                end
                PH_READ4:
                begin
                    shreg = {shreg[23:0], r.rx};
                    nbytes++;
                    if (nbytes < 10'd4) push_xfer(8'hff, 1'b1);
                    else
                    begin
                        if (cmd == CMD_IF_COND) v2 = (shreg[11:0] == 12'h1aa);
                        else
                        begin
                            ocr = shreg;
                            hc = v2 && ocr[30];
                        end
                        go_desel(ST_OK);
                    end
                end
                PH_DESEL: on_desel();
                PH_TOKEN:
                    if (r.rx == 8'hfe)
                    begin
                        ph = PH_DATA;
                        nbytes = '0;
                        push_xfer(8'hff, 1'b1);
                    end
                    else if (ms < tok_to) push_xfer(8'hff, 1'b1);
                    else go_desel(ST_TOKEN_TO);
                PH_DATA:
                begin
                    e = '{default: '0};
                    e.kind = KIND_DATA;
                    e.data = r.rx;
                    e.last = (32'(nbytes) + 1 >= BLK);
                    card_out_q.push_back(e);
                    nbytes++;
                    if (nbytes >= BLK)
                    begin
                        ph = PH_CRC;
                        nbytes = '0;
                        n_blocks++;
                    end
                    push_xfer(8'hff, 1'b1);
                end
                PH_CRC:
                begin
                    nbytes++;
                    if (nbytes < 10'd2) push_xfer(8'hff, 1'b1);
                    else go_desel(ST_OK);
                end
                default: ;
            endcase
    endtask

    // plays the card: mostly sane answers, some garbage
    function automatic logic [7:0] card_byte();
        int p;
        p = $urandom_range(0, 99);
        if (p < fail_pct) return 8'($urandom);
        case (ph)
            PH_POLL:
                if (p % 4 == 0) return 8'hff;
                else
                    case (cmd)
                        CMD_GO_IDLE: return 8'h01;
                        CMD_IF_COND: return (p % 5 == 1) ? 8'h05 : 8'h01;
                        CMD_APP: return (p % 2) ? 8'h01 : 8'h00;
                        CMD_OP_COND: return (p % 2) ? 8'h01 : 8'h00;
                        default: return 8'h00;
                    endcase
            PH_READ4:
                if (cmd == CMD_IF_COND)
                    return (nbytes == 10'd2) ? 8'h01 : (nbytes == 10'd3) ? 8'haa : 8'h00;
                else return 8'($urandom);
            PH_TOKEN: return (p % 10 < 7) ? 8'hfe : 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_lba();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic make_request(output req_t r, output bit counted);
        int p;
        p = $urandom_range(0, 99);
        r.lba = $urandom;
        r.rx = 8'($urandom);
        counted = 1'b1;
        if (ph == PH_IDLE)
        begin
            if (!ready && p < 70 || ready && p < 8) r.act = ACT_START;
            else if (p < 80) r.act = ACT_READ;
            else if (p < 90) r.act = ACT_TICK;
            else
            begin
                r.act = ACT_BYTE;
                counted = 1'b0;
            end
            if (r.act == ACT_READ) r.lba = pick_lba();
        end
        else if (p < tick_pct) r.act = ACT_TICK;
        else if (p < tick_pct + 3)
        begin
            r.act = (p % 2) ? ACT_START : ACT_READ;
            counted = 1'b0;
        end
        else
        begin
            r.act = ACT_BYTE;
            r.rx = card_byte();
        end
    endtask

    task automatic queue_request(input req_t r);
        req_q.push_back(r);
        host_step(r);
    endtask

    task automatic run_phase(input int budget);
        req_t r;
        bit   counted;
        int   n;
        n = 0;
        while (n < budget || ph != PH_IDLE)
        begin
            if (n >= budget) fail_pct = 0;
            make_request(r, counted);
            queue_request(r);
            if (counted) n++;
        end
    endtask

    task automatic drain();
        while (req_q.size() != 0 || in_valid || card_out_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SLOW: slow_div = val[7:0];
            REG_FAST: fast_div = val[7:0];
            REG_INITT: init_to = val;
            default: tok_to = val;
        endcase
    endtask

    task automatic set_all(input logic [15:0] s, input logic [15:0] f,
                           input logic [15:0] it, input logic [15:0] tt);
        write_reg(REG_SLOW, s);
        write_reg(REG_FAST, f);
        write_reg(REG_INITT, it);
        write_reg(REG_TOKT, tt);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", n_results, what,
                 got, want);
        errors++;
    endtask

    // request driver
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        req_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (in_valid && in_stall)
        begin
        end
        else if (in_gap != 0)
        begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end
        else if (req_q.size() != 0)
        begin
            r = req_q.pop_front();
            in_valid <= 1'b1;
            action <= r.act;
            block_address <= r.lba;
            received_byte <= r.rx;
            in_gap <= idle_mode ? $urandom_range(0, 8) : 0;
        end
        else in_valid <= 1'b0;
    end

    // result monitor
    int out_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        card_out_t e;
        int        g;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            g = (out_gap != 0) ? out_gap - 1 : 0;
            if (out_valid && !out_stall)
            begin
                if (card_out_q.size() == 0)
                    report("unexpected kind", 32'(kind), 32'h0);
                else
                begin
                    e = card_out_q.pop_front();
                    if (kind !== e.kind) report("kind", 32'(kind), 32'(e.kind));
                    if (tx_byte !== e.tx) report("tx_byte", 32'(tx_byte), 32'(e.tx));
                    if (select_low !== e.sel)
                        report("select_low", 32'(select_low), 32'(e.sel));
                    if (spi_divider !== e.div)
                        report("spi_divider", 32'(spi_divider), 32'(e.div));
                    if (data_byte !== e.data)
                        report("data_byte", 32'(data_byte), 32'(e.data));
                    if (last_data !== e.last)
                        report("last_data", 32'(last_data), 32'(e.last));
                    if (status !== e.st) report("status", 32'(status), 32'(e.st));
                    if (card_response !== e.resp)
                        report("card_response", 32'(card_response), 32'(e.resp));
                    if (capacity_high !== e.cap)
                        report("capacity_high", 32'(capacity_high), 32'(e.cap));
                    if (card_ocr !== e.ocr) report("card_ocr", card_ocr, e.ocr);
                end
                n_results++;
                g = idle_mode ? $urandom_range(0, 8) : 0;
            end
            out_gap <= g;
            out_stall <= hold || (g != 0);
        end
    end

    // long receiver hold-off and run limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        hold <= (cyc >= 3000 && cyc < 3400);
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", card_out_q.size());
            $display("sd_spi_init_and_block_read regression: fail");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: read before init, stray byte, tick; then random clean inits, edge reads
        idle_mode = 1;
        r = '{ACT_READ, 32'hffff_ffff, 8'h00};
        queue_request(r);
        r = '{ACT_BYTE, 32'h0, 8'hff};
        queue_request(r);
        r = '{ACT_TICK, 32'h0, 8'h00};
        queue_request(r);
        fail_pct = 0;
        tick_pct = 2;
        run_phase(500);
        drain();

        set_all(16'd0, 16'd255, 16'd0, 16'd0);
        idle_mode = 0;
        fail_pct = 10;
        tick_pct = 10;
        run_phase(450);
        drain();

        set_all(16'd255, 16'd0, 16'hffff, 16'hffff);
        idle_mode = 1;
        fail_pct = 3;
        tick_pct = 4;
        run_phase(500);
        drain();

        set_all(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 16'd3, 16'd2);
        fail_pct = 15;
        tick_pct = 20;
        run_phase(500);
        drain();

        $display("covered %0d inits and %0d full block reads, %0d results checked",
                 n_inits, n_blocks, n_results);
        if (errors == 0)
            $display("sd_spi_init_and_block_read regression: pass");
        else
            $display("sd_spi_init_and_block_read regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
